@@ rtl/hpie_pkg.sv @@
// Shared types and constants for the HPACK prefix integer encoder.
package hpie_pkg;

   // Request kinds
   localparam logic [1:0] KIND_INDEXED     = 2'd0;
   localparam logic [1:0] KIND_SIZE_UPDATE = 2'd1;
   localparam logic [1:0] KIND_PLAIN       = 2'd2;

   // Flags ORed into the first byte, and 7-bit group coding
   localparam logic [7:0] FLAG_INDEXED     = 8'h80;
   localparam logic [7:0] FLAG_SIZE_UPDATE = 8'h20;
   localparam logic [7:0] FLAG_NONE        = 8'h00;
   localparam logic [6:0] GROUP_MASK       = 7'h7f;
   localparam logic [7:0] GROUP_CONT       = 8'd128;

   // Prefix widths
   localparam logic [3:0] PREFIX_INDEXED     = 4'd7;
   localparam logic [3:0] PREFIX_SIZE_UPDATE = 4'd5;
   localparam logic [3:0] PREFIX_MIN         = 4'd1;
   localparam logic [3:0] PREFIX_MAX         = 4'd8;

   // Classified request: first byte plus the remainder still to send
   typedef struct packed {
      logic [7:0]  first_byte;
      logic        has_rem;
      logic [63:0] rem;
   } hpie_item_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } hpie_qstat_type;

endpackage

@@ rtl/hpie_front.sv @@
// Front end: classifies a request into its first byte and remainder.
module hpie_front import hpie_pkg::*; (
   input  logic [1:0]    req_type,
   input  logic [63:0]   req_value,
   input  logic [3:0]    req_prefix_bits,
   output hpie_item_type item
);

   logic [3:0] pbits;
   logic [7:0] flag;
   logic [7:0] maxv;
   logic       fits;

   // Prefix width and flag per request kind
   always_comb begin
      case (req_type)
         KIND_INDEXED: begin
            pbits = PREFIX_INDEXED;
            flag  = FLAG_INDEXED;
         end
         KIND_SIZE_UPDATE: begin
            pbits = PREFIX_SIZE_UPDATE;
            flag  = FLAG_SIZE_UPDATE;
         end
         default: begin
            // plain integer, unused kind treated the same
            if (req_prefix_bits < PREFIX_MIN) begin
               pbits = PREFIX_MIN;
            end else if (req_prefix_bits > PREFIX_MAX) begin
               pbits = PREFIX_MAX;
            end else begin
               pbits = req_prefix_bits;
            end
            flag = FLAG_NONE;
         end
      endcase
   end

   // All-ones prefix value and the fit test
   assign maxv = 8'((9'd1 << pbits) - 9'd1);
   assign fits = req_value < {56'd0, maxv};

   always_comb begin
      item.has_rem    = !fits;
      item.first_byte = fits ? (req_value[7:0] | flag) : (maxv | flag);
      item.rem        = req_value - {56'd0, maxv};
   end

endmodule

@@ rtl/hpie_queue.sv @@
// Short request queue between the front and back ends.
module hpie_queue import hpie_pkg::*; #(
   parameter int QDEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  hpie_item_type  wr_data,
   input  logic           rd_en,
   output hpie_item_type  rd_data,
   output hpie_qstat_type stat
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   hpie_item_type entries_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data    = entries_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(QDEPTH));

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QDEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en && !rd_en |-> count_ff != CW'(QDEPTH))
      else $error("write into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> count_ff != '0)
      else $error("read from empty queue");

endmodule

@@ rtl/hpie_back.sv @@
// Back end: sends the first byte, then 7-bit groups, one byte per cycle while each byte is popped.
module hpie_back import hpie_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  hpie_item_type  head,
   input  hpie_qstat_type qstat,
   output logic           q_pop,
   input  logic           pop,
   output logic           empty,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last
);

   logic        busy_ff, busy_in;
   logic [63:0] rem_ff, rem_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        advance;
   logic        more;

   // Output register is free when empty or being taken
   assign advance = !out_valid_ff || pop;
   assign more    = (rem_ff[63:7] != '0);
   assign q_pop   = advance && !busy_ff && !qstat.empty;

   // Byte sequencer
   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (busy_ff) begin
            out_valid_in = 1'b1;
            if (more) begin
               out_byte_in = GROUP_CONT | {1'b0, rem_ff[6:0] & GROUP_MASK};
               out_last_in = 1'b0;
               rem_in      = rem_ff >> 7;
            end else begin
               out_byte_in = {1'b0, rem_ff[6:0]};
               out_last_in = 1'b1;
               busy_in     = 1'b0;
            end
         end else if (!qstat.empty) begin
            // start a new request with its first byte
            out_valid_in = 1'b1;
            out_byte_in  = head.first_byte;
            out_last_in  = !head.has_rem;
            busy_in      = head.has_rem;
            rem_in       = head.rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign empty        = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

   // Checks
   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> out_valid_ff && !out_last_ff)
      else $error("busy without a pending non-final byte");
   a_open_run_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_last_ff |-> busy_ff)
      else $error("non-final byte with no request in progress");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_pop)
      else $error("queue read while a request is in progress");

endmodule

@@ rtl/hpack_prefix_integer_encoder.sv @@
// HPACK prefix integer encoder: classifies requests, queues them, emits bytes.
// The first byte of a request passes through the queue and then the back-end
// output register on its way to the result ports.
// Throughput: one byte per cycle while each byte is popped; a request of n
// bytes (1 to 11) holds the back-end byte sequencer until its last byte.
// Reset (synchronous): empties the queue and the output register.
module hpack_prefix_integer_encoder import hpie_pkg::*; #(
   parameter int QDEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_value,
   input  logic [3:0]  req_prefix_bits,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   hpie_item_type  front_item;
   hpie_item_type  head;
   hpie_qstat_type qstat;
   logic           q_push;
   logic           q_pop;

   assign full   = qstat.full;
   assign q_push = push && !qstat.full;

   hpie_front u_front (
      .req_type        (req_type),
      .req_value       (req_value),
      .req_prefix_bits (req_prefix_bits),
      .item            (front_item)
   );

   hpie_queue #(
      .QDEPTH (QDEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (front_item),
      .rd_en   (q_pop),
      .rd_data (head),
      .stat    (qstat)
   );

   hpie_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .qstat        (qstat),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the HPACK prefix integer encoder: directed table, then random requests.
module tb;
   import hpie_pkg::*;

   // Request kind 3 is unused and must behave as a plain integer
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 96;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 250;
   localparam int HOLD_AFTER = 40;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
   } enc_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic [3:0]  width;
      logic        known;
      logic [7:0]  known_byte;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [1:0]  req_type = KIND_INDEXED;
   logic [63:0] req_value = '0;
   logic [3:0]  req_prefix_bits = '0;
   logic        full;
   logic        empty;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   enc_byte_type expected_bytes[$];
   int           mismatches = 0;
   int           burst_left = 0;
   int           idle_cycles = 0;

   // Directed requests; single-byte encodings carry their byte inline
   request_type directed_reqs [0:23] = '{
      '{KIND_INDEXED,     64'd0,                4'd0,  1'b1, 8'h80},
      '{KIND_INDEXED,     64'd126,              4'd0,  1'b1, 8'hfe},
      '{KIND_INDEXED,     64'd127,              4'd0,  1'b0, 8'h00},
      '{KIND_INDEXED,     64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 8'h00},
      '{KIND_INDEXED,     64'd5,                4'd3,  1'b1, 8'h85},
      '{KIND_SIZE_UPDATE, 64'd0,                4'd0,  1'b1, 8'h20},
      '{KIND_SIZE_UPDATE, 64'd30,               4'd0,  1'b1, 8'h3e},
      '{KIND_SIZE_UPDATE, 64'd31,               4'd0,  1'b0, 8'h00},
      '{KIND_SIZE_UPDATE, 64'd1337,             4'd0,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'd0,                4'd1,  1'b1, 8'h00},
      '{KIND_PLAIN,       64'd1,                4'd1,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'hffff_ffff_ffff_ffff, 4'd1, 1'b0, 8'h00},
      '{KIND_PLAIN,       64'd254,              4'd8,  1'b1, 8'hfe},
      '{KIND_PLAIN,       64'd255,              4'd8,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 8'h00},
      '{KIND_PLAIN,       64'd0,                4'd0,  1'b1, 8'h00},
      '{KIND_PLAIN,       64'd5,                4'd0,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'd200,              4'd15, 1'b1, 8'hc8},
      '{KIND_PLAIN,       64'd300,              4'd9,  1'b0, 8'h00},
      '{KIND_UNUSED,      64'd10,               4'd4,  1'b1, 8'h0a},
      '{KIND_UNUSED,      64'd15,               4'd4,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'd158,              4'd5,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'd159,              4'd5,  1'b0, 8'h00},
      '{KIND_PLAIN,       64'h8000_0000_0000_0000, 4'd3, 1'b0, 8'h00}
   };

   hpack_prefix_integer_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_prefix_bits (req_prefix_bits),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one predicted byte to the expected store
   function automatic void add_expected(input logic [7:0] octet, input logic last);
      enc_byte_type entry;
      entry.octet = octet;
      entry.last  = last;
      expected_bytes.insert(expected_bytes.size(), entry);
   endfunction

   // Predicted byte run for one request, appended to the expected store
   function automatic void encode_prefix_int(input logic [1:0] kind, input logic [63:0] value,
                                             input logic [3:0] width_in);
      logic [3:0]  width;
      logic [7:0]  flag;
      logic [63:0] prefix_max;
      logic [63:0] rest;
      case (kind)
         KIND_INDEXED: begin
            width = PREFIX_INDEXED;
            flag  = FLAG_INDEXED;
         end
         KIND_SIZE_UPDATE: begin
            width = PREFIX_SIZE_UPDATE;
            flag  = FLAG_SIZE_UPDATE;
         end
         default: begin
            // plain integer; width clamps into 1..8
            if (width_in < PREFIX_MIN)
               width = PREFIX_MIN;
            else if (width_in > PREFIX_MAX)
               width = PREFIX_MAX;
            else
               width = width_in;
            flag = FLAG_NONE;
         end
      endcase
      prefix_max = (64'd1 << width) - 64'd1;
      if (value < prefix_max) begin
         add_expected(value[7:0] | flag, 1'b1);
      end else begin
         rest = value - prefix_max;
         add_expected(prefix_max[7:0] | flag, 1'b0);
         while (rest >= 64'(GROUP_CONT)) begin
            add_expected(GROUP_CONT | {1'b0, rest[6:0] & GROUP_MASK}, 1'b0);
            rest = rest >> 7;
         end
         add_expected(rest[7:0], 1'b1);
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      mismatches++;
   endtask

   // Offer one request in the sender's burst pattern and wait for it to be taken
   task automatic send_request(input request_type r);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      req_type        <= r.kind;
      req_value       <= r.value;
      req_prefix_bits <= r.width;
      push            <= 1'b1;
      do @(posedge clock); while (full);
      if (r.known)
         add_expected(r.known_byte, 1'b1);
      else
         encode_prefix_int(r.kind, r.value, r.width);
      burst_left--;
   endtask

   // Random value biased toward prefix and group boundaries
   function automatic logic [63:0] random_value();
      logic [63:0] boundary;
      case ($urandom_range(0, 4))
         0: random_value = 64'($urandom_range(0, 300));
         1: begin
            boundary = (64'd1 << $urandom_range(1, 8)) - 64'd1;
            random_value = boundary - 64'd1 + 64'($urandom_range(0, 2));
         end
         2: begin
            boundary = 64'd1 << (7 * $urandom_range(1, 9));
            random_value = boundary + 64'($urandom_range(0, 300)) - 64'd150;
         end
         3: random_value = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: random_value = {$urandom, $urandom};
      endcase
   endfunction

   // Stimulus: reset, directed table, random requests, then drain
   initial begin : stimulus
      request_type r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_reqs[i])
         send_request(directed_reqs[i]);
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: r.kind = KIND_INDEXED;
            3, 4:    r.kind = KIND_SIZE_UPDATE;
            9:       r.kind = KIND_UNUSED;
            default: r.kind = KIND_PLAIN;
         endcase
         r.value      = random_value();
         r.width      = 4'($urandom_range(0, 15));
         r.known      = 1'b0;
         r.known_byte = 8'h00;
         send_request(r);
      end
      push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Receiver: shifting pop rate, plus one long hold-off to back up the queue
   always @(posedge clock) begin : receiver
      static int seen_reqs = 0;
      static int hold_left = 0;
      static bit hold_done = 1'b0;
      static int pop_pct = 100;
      static int pattern_cnt = 0;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (push && !full)
            seen_reqs++;
         if (!hold_done && seen_reqs >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pattern_cnt++;
            if (pattern_cnt % 50 == 0) begin
               case ($urandom_range(0, 3))
                  0: pop_pct = 100;
                  1: pop_pct = 80;
                  2: pop_pct = 40;
                  default: pop_pct = 15;
               endcase
            end
            pop <= ($urandom_range(1, 100) <= pop_pct);
         end
      end
   end

   // Check each accepted byte against the oldest prediction
   always @(posedge clock) begin : check_bytes
      enc_byte_type want;
      if (!reset && pop && !empty) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", 8'h00, rsp_out_byte);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.octet)
               report_mismatch("out_byte", want.octet, rsp_out_byte);
            if (rsp_last !== want.last)
               report_mismatch("last", {7'd0, want.last}, {7'd0, rsp_last});
         end
      end
   end

   // Watchdog on cycles with no request or byte moving
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d bytes outstanding", expected_bytes.size());
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

@@ sim.f @@
rtl/hpie_pkg.sv
rtl/hpie_front.sv
rtl/hpie_queue.sv
rtl/hpie_back.sv
rtl/hpack_prefix_integer_encoder.sv
bench/tb.sv
